// ----- rtl/pbsq_pkg.sv -----
// ----------------------------------------------------------------------------
// pbsq_pkg
// Shared widths, operation and status codes, register indexes and the
// controller/datapath handshake types of the priority bin scheduler queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pbsq_pkg;

    // Payload field widths
    localparam int FUNC_W     = 2;
    localparam int HANDLE_W   = 8;
    localparam int PRIO_W     = 4;
    localparam int POS_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int EP_W       = 8;
    localparam int SIZE_W     = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int NUM_EP     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_EN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EP0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EP1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EP2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EP3     = 3'd4;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ERASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

    // Default sizing
    localparam int DEF_PRIORITY_LEVELS = 16;
    localparam int DEF_BIN_DEPTH       = 16;
    localparam int DEF_BUCKET_SIZE     = 4;
    localparam int DEF_BUCKET_COUNT    = 4;

    // Controller -> datapath step commands
    typedef struct packed {
        logic load;     // latch a new word
        logic dec;      // decode bin state, do add / clear
        logic er1;      // erase: capture removed handle, read last entry
        logic er2;      // erase: move last entry, shrink bin
        logic srch;     // one step of the downward top search
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic erase_go;     // erase is legal, run the erase steps
        logic srch_need;    // top bin emptied, search lower levels
        logic srch_done;    // search step ends the search
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/pbsq_in_if.sv -----
// ----------------------------------------------------------------------------
// pbsq_in_if
// Request channel: valid/ready handshake with the operation word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbsq_in_if;
    logic                           valid;
    logic                           ready;
    logic [pbsq_pkg::FUNC_W-1:0]    func;
    logic [pbsq_pkg::HANDLE_W-1:0]  handle;
    logic [pbsq_pkg::PRIO_W-1:0]    priority_req;
    logic                           is_barrier;
    logic [pbsq_pkg::POS_W-1:0]     position;

    modport source (output valid, func, handle, priority_req, is_barrier, position,
                    input ready);
    modport sink   (input valid, func, handle, priority_req, is_barrier, position,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/pbsq_out_if.sv -----
// ----------------------------------------------------------------------------
// pbsq_out_if
// Result channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbsq_out_if;
    logic                           valid;
    logic                           ready;
    logic [pbsq_pkg::STATUS_W-1:0]  status;
    logic [pbsq_pkg::PRIO_W-1:0]    effective_priority;
    logic [pbsq_pkg::EP_W-1:0]      endpoint;
    logic [pbsq_pkg::SIZE_W-1:0]    bin_size;
    logic [pbsq_pkg::POS_W-1:0]     next_index;
    logic [pbsq_pkg::HANDLE_W-1:0]  removed_handle;
    logic [pbsq_pkg::PRIO_W-1:0]    top_priority;
    logic                           queue_nonempty;

    modport source (output valid, status, effective_priority, endpoint, bin_size,
                    next_index, removed_handle, top_priority, queue_nonempty,
                    input ready);
    modport sink   (input valid, status, effective_priority, endpoint, bin_size,
                    next_index, removed_handle, top_priority, queue_nonempty,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/priority_bin_scheduler_queue.sv -----
// ----------------------------------------------------------------------------
// priority_bin_scheduler_queue
// Per-priority bins of task handles with tracking of the highest busy level.
//
// Request channel i_in carries one operation word (add, erase, clear); result
// channel o_out returns exactly one result word per request. Both use a
// valid/ready handshake. Registers (priority mode, four bucket endpoints) are
// written through i_cfg_we / i_cfg_idx / i_cfg_wdata. The user must write them
// only while the block is idle; the block itself does not enforce this.
//
// One request is in flight at a time. An add, a clear or an unused code runs
// through the accepting cycle, a fill/endpoint memory read, a decode-and-write
// cycle and the result cycle. A legal erase adds a step that reads the bin's
// last slot and one that moves it into the erased slot. When an erase empties
// the top bin the top is searched downward one level per cycle.
//
// Reset empties every bin, clears the registers and holds ready low; entry
// memory is not cleared. While o_out.ready is low the result word holds and
// no new request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_bin_scheduler_queue #(
    parameter int PRIORITY_LEVELS = pbsq_pkg::DEF_PRIORITY_LEVELS,
    parameter int BIN_DEPTH       = pbsq_pkg::DEF_BIN_DEPTH,
    parameter int BUCKET_SIZE     = pbsq_pkg::DEF_BUCKET_SIZE,
    parameter int BUCKET_COUNT    = pbsq_pkg::DEF_BUCKET_COUNT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pbsq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pbsq_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    pbsq_in_if.sink                              i_in,
    pbsq_out_if.source                           o_out
);

    pbsq_pkg::t_cmd cmd;
    pbsq_pkg::t_sts sts;
    logic           in_ready;
    logic           out_valid;

    // sequencer
    pbsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid)
    );

    // bins, tracking and result word
    pbsq_dpath #(
        .PRIORITY_LEVELS (PRIORITY_LEVELS),
        .BIN_DEPTH       (BIN_DEPTH),
        .BUCKET_SIZE     (BUCKET_SIZE),
        .BUCKET_COUNT    (BUCKET_COUNT)
    ) u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_func               (i_in.func),
        .i_handle             (i_in.handle),
        .i_priority_req       (i_in.priority_req),
        .i_is_barrier         (i_in.is_barrier),
        .i_position           (i_in.position),
        .o_status             (o_out.status),
        .o_effective_priority (o_out.effective_priority),
        .o_endpoint           (o_out.endpoint),
        .o_bin_size           (o_out.bin_size),
        .o_next_index         (o_out.next_index),
        .o_removed_handle     (o_out.removed_handle),
        .o_top_priority       (o_out.top_priority),
        .o_queue_nonempty     (o_out.queue_nonempty)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

`default_nettype wire

// ----- rtl/pbsq_ctrl.sv -----
// ----------------------------------------------------------------------------
// pbsq_ctrl
// Sequencer: steps one word through bin read, decode, erase and top search.
// ----------------------------------------------------------------------------
`default_nettype none

module pbsq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_out_ready,
    input  wire pbsq_pkg::t_sts i_sts,
    output pbsq_pkg::t_cmd      o_cmd,
    output logic                o_in_ready,
    output logic                o_out_valid
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FRD  = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_ER1  = 3'd3;
    localparam logic [2:0] S_ER2  = 3'd4;
    localparam logic [2:0] S_SRCH = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_FRD;
            S_FRD:  n_state = S_DEC;
            S_DEC:  n_state = i_sts.erase_go ? S_ER1 : S_OUT;
            S_ER1:  n_state = S_ER2;
            S_ER2:  n_state = i_sts.srch_need ? S_SRCH : S_OUT;
            S_SRCH: if (i_sts.srch_done) n_state = S_OUT;
            S_OUT:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands and handshakes; no word is taken while reset is held
    always_comb begin
        o_cmd.load  = (r_state == S_IDLE) && i_rst_n && i_in_valid;
        o_cmd.dec   = (r_state == S_DEC);
        o_cmd.er1   = (r_state == S_ER1);
        o_cmd.er2   = (r_state == S_ER2);
        o_cmd.srch  = (r_state == S_SRCH);
        o_in_ready  = (r_state == S_IDLE) && i_rst_n;
        o_out_valid = (r_state == S_OUT);
    end

endmodule

`default_nettype wire

// ----- rtl/pbsq_dpath.sv -----
// ----------------------------------------------------------------------------
// pbsq_dpath
// Datapath: config registers, bin entry memory, fill/endpoint memory,
// non-empty flags, top tracking and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pbsq_dpath #(
    parameter int PRIORITY_LEVELS = pbsq_pkg::DEF_PRIORITY_LEVELS,
    parameter int BIN_DEPTH       = pbsq_pkg::DEF_BIN_DEPTH,
    parameter int BUCKET_SIZE     = pbsq_pkg::DEF_BUCKET_SIZE,
    parameter int BUCKET_COUNT    = pbsq_pkg::DEF_BUCKET_COUNT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_we,
    input  wire logic [pbsq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [pbsq_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // control
    input  wire pbsq_pkg::t_cmd                 i_cmd,
    output pbsq_pkg::t_sts                      o_sts,
    // request word
    input  wire logic [pbsq_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [pbsq_pkg::HANDLE_W-1:0]  i_handle,
    input  wire logic [pbsq_pkg::PRIO_W-1:0]    i_priority_req,
    input  wire logic                           i_is_barrier,
    input  wire logic [pbsq_pkg::POS_W-1:0]     i_position,
    // result word
    output logic [pbsq_pkg::STATUS_W-1:0]       o_status,
    output logic [pbsq_pkg::PRIO_W-1:0]         o_effective_priority,
    output logic [pbsq_pkg::EP_W-1:0]           o_endpoint,
    output logic [pbsq_pkg::SIZE_W-1:0]         o_bin_size,
    output logic [pbsq_pkg::POS_W-1:0]          o_next_index,
    output logic [pbsq_pkg::HANDLE_W-1:0]       o_removed_handle,
    output logic [pbsq_pkg::PRIO_W-1:0]         o_top_priority,
    output logic                                o_queue_nonempty
);

    localparam int LVL_W     = $clog2(PRIORITY_LEVELS);
    localparam int FILL_W    = $clog2(BIN_DEPTH + 1);
    localparam int OFS_W     = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
    localparam int CMP_W     = (FILL_W > pbsq_pkg::POS_W) ? FILL_W : pbsq_pkg::POS_W;
    localparam int ENT_DEPTH = PRIORITY_LEVELS * BIN_DEPTH;
    localparam int ADDR_W    = $clog2(ENT_DEPTH);
    localparam int LVL_MAX   = PRIORITY_LEVELS - 1;
    localparam int EP_W      = pbsq_pkg::EP_W;
    localparam int FM_W      = EP_W + FILL_W;

    // configuration registers
    logic            r_prio_en;
    logic [EP_W-1:0] r_ep [pbsq_pkg::NUM_EP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio_en <= 1'b0;
            for (int i = 0; i < pbsq_pkg::NUM_EP; i++) r_ep[i] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pbsq_pkg::CFG_PRIO_EN: r_prio_en <= i_cfg_wdata[0];
                pbsq_pkg::CFG_EP0:     r_ep[0]   <= i_cfg_wdata;
                pbsq_pkg::CFG_EP1:     r_ep[1]   <= i_cfg_wdata;
                pbsq_pkg::CFG_EP2:     r_ep[2]   <= i_cfg_wdata;
                pbsq_pkg::CFG_EP3:     r_ep[3]   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // latched operation
    logic [pbsq_pkg::FUNC_W-1:0]   r_func;
    logic [pbsq_pkg::HANDLE_W-1:0] r_handle;
    logic [LVL_W-1:0]              r_level;
    logic [CMP_W-1:0]              r_pos;
    logic [LVL_W-1:0]              r_cnt;

    // bin tracking state
    logic [PRIORITY_LEVELS-1:0]    r_nonempty;
    logic [LVL_W-1:0]              r_top;
    logic                          r_top_valid;

    // result registers
    logic [pbsq_pkg::STATUS_W-1:0] r_status;
    logic [LVL_W-1:0]              r_eff;
    logic [EP_W-1:0]               r_ep_out;
    logic [FILL_W-1:0]             r_size;
    logic [CMP_W-1:0]              r_nidx;
    logic [pbsq_pkg::HANDLE_W-1:0] r_removed;

    // memories
    logic [FM_W-1:0]               fmem [PRIORITY_LEVELS];
    logic [FM_W-1:0]               r_fq;
    logic [pbsq_pkg::HANDLE_W-1:0] emem [ENT_DEPTH];
    logic [pbsq_pkg::HANDLE_W-1:0] r_eq;

    // bucket of each level, a constant table
    logic [1:0] bucket_of [PRIORITY_LEVELS];

    for (genvar g = 0; g < PRIORITY_LEVELS; g++) begin : g_bucket
        assign bucket_of[g] = 2'((g / BUCKET_SIZE) % BUCKET_COUNT);
    end

    // request level: saturate, then barrier override
    logic [LVL_W-1:0] sat_level;
    logic [LVL_W-1:0] req_level;

    always_comb begin
        sat_level = (32'(i_priority_req) > LVL_MAX) ? LVL_W'(LVL_MAX)
                                                     : LVL_W'(i_priority_req);
        req_level = sat_level;
        if (i_func == pbsq_pkg::FUNC_ADD && r_prio_en && i_is_barrier) begin
            req_level = r_top;
        end
    end

    // bin decode
    logic [FILL_W-1:0] cur_fill;
    logic [EP_W-1:0]   cur_ep;
    logic [EP_W-1:0]   new_ep;
    logic [1:0]        bucket;
    logic [FILL_W-1:0] last;
    logic              full;
    logic              fill_zero;
    logic              pos_ok;
    logic              add_ok;
    logic              top_hit;
    logic [LVL_W-1:0]  srch_idx;

    always_comb begin
        cur_fill  = r_nonempty[r_level] ? r_fq[FILL_W-1:0] : '0;
        cur_ep    = r_fq[FILL_W +: EP_W];
        bucket    = bucket_of[r_level];
        new_ep    = r_prio_en ? r_ep[bucket] : r_ep[0];
        last      = cur_fill - FILL_W'(1);
        full      = (cur_fill == FILL_W'(BIN_DEPTH));
        fill_zero = (cur_fill == '0);
        pos_ok    = (r_pos < CMP_W'(cur_fill));
        add_ok    = (r_func == pbsq_pkg::FUNC_ADD) && !full;
        top_hit   = (last == '0) && r_top_valid && (r_level == r_top);
        srch_idx  = r_cnt - LVL_W'(1);

        o_sts.erase_go  = (r_func == pbsq_pkg::FUNC_ERASE) && !fill_zero && pos_ok;
        o_sts.srch_need = top_hit && (r_level != '0);
        o_sts.srch_done = r_nonempty[srch_idx] || (srch_idx == '0);
    end

    // fill / endpoint memory, one row per level
    logic            fm_we;
    logic [FM_W-1:0] fm_wdata;

    always_comb begin
        fm_we    = (i_cmd.dec && add_ok) || i_cmd.er2;
        fm_wdata = i_cmd.er2 ? {cur_ep, last}
                             : {(fill_zero ? new_ep : cur_ep), cur_fill + FILL_W'(1)};
    end

    always_ff @(posedge i_clk) begin
        if (fm_we) begin
            fmem[r_level] <= fm_wdata;
        end
        r_fq <= fmem[r_level];
    end

    // entry memory: read slot at pos, then at last; write on add or move
    logic [OFS_W-1:0]              rd_ofs;
    logic [OFS_W-1:0]              wr_ofs;
    logic [ADDR_W-1:0]             rd_addr;
    logic [ADDR_W-1:0]             wr_addr;
    logic                          em_we;
    logic [pbsq_pkg::HANDLE_W-1:0] em_wdata;

    always_comb begin
        rd_ofs   = i_cmd.er1 ? last[OFS_W-1:0] : r_pos[OFS_W-1:0];
        wr_ofs   = i_cmd.er2 ? r_pos[OFS_W-1:0] : cur_fill[OFS_W-1:0];
        rd_addr  = ADDR_W'(32'(r_level) * BIN_DEPTH + 32'(rd_ofs));
        wr_addr  = ADDR_W'(32'(r_level) * BIN_DEPTH + 32'(wr_ofs));
        em_we    = (i_cmd.dec && add_ok) || i_cmd.er2;
        em_wdata = i_cmd.er2 ? r_eq : r_handle;
    end

    always_ff @(posedge i_clk) begin
        if (em_we) begin
            emem[wr_addr] <= em_wdata;
        end
        r_eq <= emem[rd_addr];
    end

    // operation registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_func;
            r_handle <= i_handle;
            r_level  <= req_level;
            r_pos    <= CMP_W'(i_position);
        end
        if (i_cmd.er2) begin
            r_cnt <= r_level;
        end else if (i_cmd.srch) begin
            r_cnt <= srch_idx;
        end
    end

    // non-empty flags and top level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty  <= '0;
            r_top       <= '0;
            r_top_valid <= 1'b0;
        end else begin
            if (i_cmd.dec && add_ok) begin
                r_nonempty[r_level] <= 1'b1;
                if (fill_zero && (!r_top_valid || r_level >= r_top)) begin
                    r_top       <= r_level;
                    r_top_valid <= 1'b1;
                end
            end
            if (i_cmd.dec && r_func == pbsq_pkg::FUNC_CLEAR) begin
                r_nonempty  <= '0;
                r_top       <= '0;
                r_top_valid <= 1'b0;
            end
            if (i_cmd.er2 && last == '0) begin
                r_nonempty[r_level] <= 1'b0;
                // top at level zero emptied: nothing lower to search
                if (top_hit && r_level == '0) begin
                    r_top       <= '0;
                    r_top_valid <= 1'b0;
                end
            end
            if (i_cmd.srch) begin
                if (r_nonempty[srch_idx]) begin
                    r_top       <= srch_idx;
                    r_top_valid <= 1'b1;
                end else if (srch_idx == '0) begin
                    r_top       <= '0;
                    r_top_valid <= 1'b0;
                end
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status  <= pbsq_pkg::STATUS_OK;
            r_eff     <= '0;
            r_ep_out  <= '0;
            r_size    <= '0;
            r_nidx    <= '0;
            r_removed <= '0;
        end
        if (i_cmd.dec) begin
            case (r_func)
                pbsq_pkg::FUNC_ADD: begin
                    r_eff <= r_level;
                    if (full) begin
                        r_status <= pbsq_pkg::STATUS_FULL;
                        r_ep_out <= cur_ep;
                        r_size   <= cur_fill;
                    end else begin
                        r_ep_out <= fill_zero ? new_ep : cur_ep;
                        r_size   <= cur_fill + FILL_W'(1);
                    end
                end
                pbsq_pkg::FUNC_ERASE: begin
                    r_eff <= r_level;
                    if (fill_zero) begin
                        r_status <= pbsq_pkg::STATUS_BAD;
                    end else if (!pos_ok) begin
                        r_status <= pbsq_pkg::STATUS_BAD;
                        r_ep_out <= cur_ep;
                        r_size   <= cur_fill;
                    end else begin
                        r_ep_out <= cur_ep;
                        r_size   <= last;
                        r_nidx   <= r_pos;
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.er1) begin
            r_removed <= r_eq;
        end
    end

    assign o_status             = r_status;
    assign o_effective_priority = pbsq_pkg::PRIO_W'(r_eff);
    assign o_endpoint           = r_ep_out;
    assign o_bin_size           = pbsq_pkg::SIZE_W'(r_size);
    assign o_next_index         = pbsq_pkg::POS_W'(r_nidx);
    assign o_removed_handle     = r_removed;
    assign o_top_priority       = pbsq_pkg::PRIO_W'(r_top);
    assign o_queue_nonempty     = r_top_valid;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the priority bin scheduler queue. A clocked driver
// feeds request words from a backlog, a clocked monitor predicts each accepted
// request against a shadow of the bins and compares every result word field by
// field. Directed requests cover the corner cases. Random phases then run
// under several register settings, with gaps on both channels and a long
// result hold-off.
// ----------------------------------------------------------------------------

module testbench;

    localparam int LEVELS  = pbsq_pkg::DEF_PRIORITY_LEVELS;
    localparam int DEPTH   = pbsq_pkg::DEF_BIN_DEPTH;
    localparam int BUCKET  = pbsq_pkg::DEF_BUCKET_SIZE;
    localparam int BUCKETS = pbsq_pkg::DEF_BUCKET_COUNT;
    localparam int NUM_EP  = pbsq_pkg::NUM_EP;

    // code 3 has no operation behind it
    localparam logic [pbsq_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int RANDOM_PER_PHASE = 200;
    localparam int LONG_HOLD        = 300;

    typedef struct packed {
        logic [pbsq_pkg::FUNC_W-1:0]   func;
        logic [pbsq_pkg::HANDLE_W-1:0] handle;
        logic [pbsq_pkg::PRIO_W-1:0]   priority_req;
        logic                          is_barrier;
        logic [pbsq_pkg::POS_W-1:0]    position;
    } t_sched_op;

    typedef struct packed {
        logic [pbsq_pkg::STATUS_W-1:0] status;
        logic [pbsq_pkg::PRIO_W-1:0]   effective_priority;
        logic [pbsq_pkg::EP_W-1:0]     endpoint;
        logic [pbsq_pkg::SIZE_W-1:0]   bin_size;
        logic [pbsq_pkg::POS_W-1:0]    next_index;
        logic [pbsq_pkg::HANDLE_W-1:0] removed_handle;
        logic [pbsq_pkg::PRIO_W-1:0]   top_priority;
        logic                          queue_nonempty;
    } t_sched_result;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic                            cfg_we    = 1'b0;
    logic [pbsq_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [pbsq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    logic      drv_valid = 1'b0;
    t_sched_op drv_op    = '0;
    logic      rcv_ready = 1'b0;

    pbsq_in_if  req_if ();
    pbsq_out_if res_if ();

    assign req_if.valid        = drv_valid;
    assign req_if.func         = drv_op.func;
    assign req_if.handle       = drv_op.handle;
    assign req_if.priority_req = drv_op.priority_req;
    assign req_if.is_barrier   = drv_op.is_barrier;
    assign req_if.position     = drv_op.position;
    assign res_if.ready        = rcv_ready;

    priority_bin_scheduler_queue u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (req_if),
        .o_out       (res_if)
    );

    // Stimulus bookkeeping
    t_sched_op     request_backlog[$];
    t_sched_result awaited_results[$];
    int            words_issued = 0;
    int            words_taken  = 0;
    logic          req_taken    = 1'b0;
    bit            idle_on      = 1'b0;
    int            hold_asks    = 0;
    int            err_cnt      = 0;

    // Generator-side fill shadow, used to build legal erases
    int gen_fill [LEVELS];
    bit gen_prio_en = 1'b0;

    // Predicted block state and registers
    logic [pbsq_pkg::HANDLE_W-1:0] bin_slots [LEVELS*DEPTH];
    int                            bin_count [LEVELS];
    logic [pbsq_pkg::EP_W-1:0]     bin_ep    [LEVELS];
    int                            top_lvl;
    bit                            top_busy;
    bit                            reg_prio_en;
    logic [pbsq_pkg::EP_W-1:0]     reg_ep    [NUM_EP];

    // Coverage tallies for the summary
    int n_add = 0, n_full = 0, n_redirect = 0, n_erase = 0, n_bad = 0;
    int n_search = 0, n_clear = 0, n_unused = 0, n_results = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Endpoint a bin latches when it turns non-empty
    function automatic logic [pbsq_pkg::EP_W-1:0] bucket_endpoint(input int lvl);
        if (!reg_prio_en) return reg_ep[0];
        return reg_ep[(lvl / BUCKET) % BUCKETS];
    endfunction

    // Advance the shadow bins by one request and return its result word
    function automatic t_sched_result apply_request(input t_sched_op op);
        t_sched_result r;
        int lvl, last, l, i;
        bit found;
        r = '0;
        // 4-bit level never exceeds LEVELS-1 here, so no saturation is needed
        lvl = int'(op.priority_req);
        case (op.func)
            pbsq_pkg::FUNC_ADD: begin
                n_add++;
                if (reg_prio_en && op.is_barrier) begin
                    lvl = top_lvl;
                    n_redirect++;
                end
                r.effective_priority = pbsq_pkg::PRIO_W'(lvl);
                if (bin_count[lvl] >= DEPTH) begin
                    r.status = pbsq_pkg::STATUS_FULL;
                    n_full++;
                end else begin
                    if (bin_count[lvl] == 0) begin
                        bin_ep[lvl] = bucket_endpoint(lvl);
                        if (!top_busy || lvl >= top_lvl) begin
                            top_lvl  = lvl;
                            top_busy = 1'b1;
                        end
                    end
                    bin_slots[lvl*DEPTH + bin_count[lvl]] = op.handle;
                    bin_count[lvl]++;
                end
                r.endpoint = bin_ep[lvl];
                r.bin_size = pbsq_pkg::SIZE_W'(bin_count[lvl]);
            end
            pbsq_pkg::FUNC_ERASE: begin
                n_erase++;
                r.effective_priority = pbsq_pkg::PRIO_W'(lvl);
                if (bin_count[lvl] == 0) begin
                    r.status = pbsq_pkg::STATUS_BAD;
                    n_bad++;
                end else if (int'(op.position) >= bin_count[lvl]) begin
                    r.status   = pbsq_pkg::STATUS_BAD;
                    r.endpoint = bin_ep[lvl];
                    r.bin_size = pbsq_pkg::SIZE_W'(bin_count[lvl]);
                    n_bad++;
                end else begin
                    // last entry moves into the erased slot
                    last = bin_count[lvl] - 1;
                    r.removed_handle = bin_slots[lvl*DEPTH + int'(op.position)];
                    bin_slots[lvl*DEPTH + int'(op.position)] = bin_slots[lvl*DEPTH + last];
                    bin_count[lvl] = last;
                    r.endpoint   = bin_ep[lvl];
                    r.bin_size   = pbsq_pkg::SIZE_W'(last);
                    r.next_index = op.position;
                    // top bin emptied: walk down to the next busy level
                    if (last == 0 && top_busy && lvl == top_lvl) begin
                        n_search++;
                        l = lvl;
                        found = 1'b0;
                        while (l > 0 && !found) begin
                            l--;
                            if (bin_count[l] != 0) found = 1'b1;
                        end
                        top_lvl  = found ? l : 0;
                        top_busy = found;
                    end
                end
            end
            pbsq_pkg::FUNC_CLEAR: begin
                n_clear++;
                for (i = 0; i < LEVELS; i++) bin_count[i] = 0;
                top_lvl  = 0;
                top_busy = 1'b0;
            end
            default: n_unused++;
        endcase
        r.top_priority   = pbsq_pkg::PRIO_W'(top_lvl);
        r.queue_nonempty = top_busy;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // Reset, register writes, prediction and result checking
    always @(posedge i_clk) begin : scoreboard
        t_sched_result want, got;
        int i;
        if (!i_rst_n) begin
            for (i = 0; i < LEVELS; i++) begin
                bin_count[i] = 0;
                bin_ep[i]    = '0;
            end
            for (i = 0; i < NUM_EP; i++) reg_ep[i] = '0;
            top_lvl     = 0;
            top_busy    = 1'b0;
            reg_prio_en = 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_idx == pbsq_pkg::CFG_PRIO_EN) begin
                    reg_prio_en = cfg_wdata[0];
                end else if (cfg_idx >= pbsq_pkg::CFG_EP0 && cfg_idx <= pbsq_pkg::CFG_EP3) begin
                    reg_ep[2'(cfg_idx - pbsq_pkg::CFG_EP0)] = cfg_wdata;
                end
            end
            if (req_if.valid && req_if.ready) begin
                awaited_results.push_back(apply_request(t_sched_op'{req_if.func,
                    req_if.handle, req_if.priority_req, req_if.is_barrier,
                    req_if.position}));
                words_taken <= words_taken + 1;
            end
            if (res_if.valid && res_if.ready) begin
                n_results++;
                got = t_sched_result'{res_if.status, res_if.effective_priority,
                    res_if.endpoint, res_if.bin_size, res_if.next_index,
                    res_if.removed_handle, res_if.top_priority, res_if.queue_nonempty};
                if (awaited_results.size() == 0) begin
                    $display("%0t: result word with nothing awaited, expected none, actual %h",
                             $time, got);
                    err_cnt++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("status", 8'(want.status), 8'(got.status));
                    compare_field("effective_priority", 8'(want.effective_priority),
                                  8'(got.effective_priority));
                    compare_field("endpoint", want.endpoint, got.endpoint);
                    compare_field("bin_size", 8'(want.bin_size), 8'(got.bin_size));
                    compare_field("next_index", 8'(want.next_index), 8'(got.next_index));
                    compare_field("removed_handle", want.removed_handle,
                                  got.removed_handle);
                    compare_field("top_priority", 8'(want.top_priority),
                                  8'(got.top_priority));
                    compare_field("queue_nonempty", 8'(want.queue_nonempty),
                                  8'(got.queue_nonempty));
                end
            end
        end
        req_taken <= req_if.valid && req_if.ready;
    end

    // Request driver: holds a word until taken, then an optional gap
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || req_taken) begin
            if (send_gap > 0) begin
                send_gap  <= send_gap - 1;
                drv_valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
                drv_op    <= request_backlog.pop_front();
                drv_valid <= 1'b1;
                send_gap  <= idle_on ? pick_gap() : 0;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus a long hold-off on request
    int rcv_gap   = 0;
    int hold_cnt  = 0;
    int hold_seen = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rcv_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt  <= hold_cnt - 1;
            rcv_ready <= 1'b0;
        end else if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_cnt  <= LONG_HOLD;
            rcv_ready <= 1'b0;
        end else if (rcv_gap > 0) begin
            rcv_gap   <= rcv_gap - 1;
            rcv_ready <= 1'b0;
        end else begin
            rcv_ready <= 1'b1;
            if (idle_on && $urandom_range(3) == 0) rcv_gap <= pick_gap();
        end
    end

    // Queue one request and track bin fill on the generator side
    task automatic push_op(input logic [pbsq_pkg::FUNC_W-1:0] f,
                           input logic [pbsq_pkg::HANDLE_W-1:0] h,
                           input logic [pbsq_pkg::PRIO_W-1:0] p, input logic b,
                           input logic [pbsq_pkg::POS_W-1:0] pos);
        int lvl, l;
        request_backlog.push_back(t_sched_op'{f, h, p, b, pos});
        words_issued++;
        case (f)
            pbsq_pkg::FUNC_ADD: begin
                lvl = int'(p);
                if (gen_prio_en && b) begin
                    // top is always the highest busy level
                    lvl = 0;
                    for (l = 0; l < LEVELS; l++) if (gen_fill[l] != 0) lvl = l;
                end
                if (gen_fill[lvl] < DEPTH) gen_fill[lvl]++;
            end
            pbsq_pkg::FUNC_ERASE: if (int'(pos) < gen_fill[p]) gen_fill[p]--;
            pbsq_pkg::FUNC_CLEAR: for (l = 0; l < LEVELS; l++) gen_fill[l] = 0;
            default: ;
        endcase
    endtask

    // Random traffic: mostly adds onto a hot level and legal erases
    task automatic gen_random(input int n, input int hot);
        int made, r, l, pick;
        int busy[$];
        made = 0;
        while (made < n) begin
            r = $urandom_range(99);
            busy = {};
            for (l = 0; l < LEVELS; l++) if (gen_fill[l] != 0) busy.push_back(l);
            if (r < 30 && busy.size() != 0) begin
                pick = busy[$urandom_range(busy.size() - 1)];
                push_op(pbsq_pkg::FUNC_ERASE, 8'($urandom_range(255)), 4'(pick),
                        1'($urandom_range(1)), 4'($urandom_range(gen_fill[pick] - 1)));
            end else if (r < 40) begin
                push_op(pbsq_pkg::FUNC_ERASE, 8'($urandom_range(255)),
                        4'($urandom_range(15)), 1'($urandom_range(1)),
                        4'($urandom_range(15)));
            end else if (r < 42) begin
                push_op(pbsq_pkg::FUNC_CLEAR, 8'($urandom_range(255)),
                        4'($urandom_range(15)), 1'($urandom_range(1)),
                        4'($urandom_range(15)));
            end else if (r < 44) begin
                // ignored code, not counted
                push_op(FUNC_UNUSED, 8'($urandom_range(255)), 4'($urandom_range(15)),
                        1'($urandom_range(1)), 4'($urandom_range(15)));
                continue;
            end else begin
                push_op(pbsq_pkg::FUNC_ADD, 8'($urandom_range(255)),
                        4'($urandom_range(1) ? hot : int'($urandom_range(15))),
                        $urandom_range(3) == 0, 4'($urandom_range(15)));
            end
            made++;
        end
    endtask

    task automatic write_reg(input logic [pbsq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pbsq_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
        if (idx == pbsq_pkg::CFG_PRIO_EN) gen_prio_en = val[0];
    endtask

    // Block until every issued word has been taken and answered
    task automatic wait_idle();
        @(negedge i_clk);
        while (words_taken != words_issued || awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Main sequence
    initial begin : sequencer
        int i, ph, k;
        logic [pbsq_pkg::EP_W-1:0] ep_val;
        for (i = 0; i < LEVELS; i++) gen_fill[i] = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, plain mode with reset registers
        @(posedge i_clk);
        idle_on = 1'b1;
        push_op(pbsq_pkg::FUNC_ERASE, 8'h00, 4'd0, 1'b0, 4'd0);   // erase on empty bin
        push_op(pbsq_pkg::FUNC_ADD, 8'h00, 4'd0, 1'b0, 4'd0);
        push_op(pbsq_pkg::FUNC_ADD, 8'hFF, 4'd15, 1'b1, 4'd15);   // barrier ignored, plain
        push_op(pbsq_pkg::FUNC_ERASE, 8'hFF, 4'd15, 1'b1, 4'd15); // index past fill
        push_op(pbsq_pkg::FUNC_ERASE, 8'h00, 4'd15, 1'b0, 4'd0);  // top empties, search
        push_op(FUNC_UNUSED, 8'hFF, 4'd15, 1'b1, 4'd15);
        push_op(pbsq_pkg::FUNC_ERASE, 8'h00, 4'd0, 1'b0, 4'd0);   // queue goes empty
        for (i = 0; i <= DEPTH; i++)                                // last add: full bin
            push_op(pbsq_pkg::FUNC_ADD, 8'(i * 15), 4'd9, 1'b0, 4'd0);
        push_op(pbsq_pkg::FUNC_ERASE, 8'h00, 4'd9, 1'b0, 4'd7);   // mid-bin erase
        push_op(pbsq_pkg::FUNC_CLEAR, 8'hFF, 4'd15, 1'b1, 4'd15);
        wait_idle();

        // Directed, priority mode
        write_reg(pbsq_pkg::CFG_PRIO_EN, 8'd1);
        write_reg(pbsq_pkg::CFG_EP0, 8'h00);
        write_reg(pbsq_pkg::CFG_EP1, 8'hFF);
        write_reg(pbsq_pkg::CFG_EP2, 8'h5A);
        write_reg(pbsq_pkg::CFG_EP3, 8'hA5);
        @(posedge i_clk);
        push_op(pbsq_pkg::FUNC_ADD, 8'h3C, 4'd12, 1'b1, 4'd0);    // barrier on empty queue
        push_op(pbsq_pkg::FUNC_ADD, 8'hC3, 4'd13, 1'b0, 4'd0);
        push_op(pbsq_pkg::FUNC_ADD, 8'h81, 4'd2, 1'b1, 4'd0);     // barrier follows top
        push_op(pbsq_pkg::FUNC_ADD, 8'h7E, 4'd6, 1'b0, 4'd0);
        wait_idle();

        // Random phases under different register settings
        for (ph = 0; ph < 4; ph++) begin
            write_reg(pbsq_pkg::CFG_PRIO_EN, 8'(ph != 1));
            for (k = 0; k < NUM_EP; k++) begin
                if (ph == 2) ep_val = (k % 2) ? 8'hFF : 8'h00;
                else if (ph == 1 && k == 0) ep_val = 8'hFF;
                else ep_val = 8'($urandom_range(255));
                write_reg(pbsq_pkg::CFG_IDX_W'(pbsq_pkg::CFG_EP0 + k), ep_val);
            end
            @(posedge i_clk);
            idle_on = (ph != 2);
            if (ph == 1) hold_asks++;
            gen_random(RANDOM_PER_PHASE, int'($urandom_range(15)));
            wait_idle();
        end

        repeat (30) @(negedge i_clk);
        $display("tb: %0d requests, %0d results; adds %0d (full %0d, barrier %0d)",
                 words_issued, n_results, n_add, n_full, n_redirect);
        $display("tb: erases %0d (rejected %0d, top searches %0d), clears %0d, unused %0d",
                 n_erase, n_bad, n_search, n_clear, n_unused);
        if (err_cnt == 0 && awaited_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
